// ===== rtl/core/mma_pkg.sv =====
// Shared types, codes and helpers for the matrix multiply-add block.
package mma_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int IDX_LIMIT   = 16;
    localparam int DIM_W       = 5;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;

    typedef enum logic [1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_LOAD_C  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_INNER = 2'd1,
        REG_COLS  = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [1:0]               func;
        logic [3:0]               row;
        logic [3:0]               col;
        logic signed [ELEM_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [3:0]              result_row;
        logic [3:0]              result_col;
        logic signed [ACC_W-1:0] result_value;
        logic                    last_in_row;
    } res_t;

    // Control bits that travel with each operand down the chain.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } flow_t;

    // Element write broadcast to every cell.
    typedef struct packed {
        logic              b_we;
        logic              c_we;
        logic [3:0]        row;
        logic [3:0]        col;
        logic [ELEM_W-1:0] data;
    } load_t;

    // Map a dimension register to its effective count: zero acts as one, clip at lim.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] val,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        begin
            r = val;
            if (val == '0)
            begin
                r = DIM_W'(1);
            end
            else if (val > lim)
            begin
                r = lim;
            end
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/mma_cell.sv =====
// One column cell: holds a column of B and C, multiplies and accumulates its D element.
module mma_cell #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF,
    parameter int IDX     = 0,
    parameter int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mma_pkg::load_t                    ld,
    input  logic [AW-1:0]                     row,
    input  logic [mma_pkg::DIM_W-1:0]         ncols,
    input  mma_pkg::flow_t                    flow_in,
    input  logic [AW-1:0]                     k_in,
    input  logic signed [mma_pkg::ELEM_W-1:0] a_in,
    output mma_pkg::flow_t                    flow_out,
    output logic [AW-1:0]                     k_out,
    output logic signed [mma_pkg::ELEM_W-1:0] a_out,
    output logic                              done,
    output logic                              last,
    output logic signed [mma_pkg::ACC_W-1:0]  res
);

    logic [mma_pkg::ELEM_W-1:0] b_mem [MAX_DIM];
    logic [mma_pkg::ELEM_W-1:0] c_mem [MAX_DIM];

    mma_pkg::flow_t                    f1_reg;
    logic [AW-1:0]                     k1_reg;
    logic signed [mma_pkg::ELEM_W-1:0] a1_reg;
    logic signed [mma_pkg::ELEM_W-1:0] b_rd_reg;
    logic signed [mma_pkg::ELEM_W-1:0] c_rd_reg;
    mma_pkg::flow_t                    f2_reg;
    logic signed [mma_pkg::PROD_W-1:0] prod_reg;
    logic signed [mma_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mma_pkg::ACC_W-1:0]  acc_next;
    logic                              done3_reg;
    logic                              done4_reg;
    logic signed [mma_pkg::ACC_W-1:0]  res_reg;
    logic                              col_hit;

    assign col_hit = (int'(ld.col) == IDX);

    always_ff @(posedge clk)
    begin
        if (ld.b_we && col_hit)
        begin
            b_mem[AW'(ld.row)] <= ld.data;
        end
        if (ld.c_we && col_hit)
        begin
            c_mem[AW'(ld.row)] <= ld.data;
        end
        b_rd_reg <= b_mem[k_in];
        c_rd_reg <= c_mem[row];
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (f2_reg.vld)
        begin
            acc_next = (f2_reg.first ? '0 : acc_reg)
                       + mma_pkg::ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg    <= '0;
            f2_reg    <= '0;
            done3_reg <= 1'b0;
            done4_reg <= 1'b0;
        end
        else
        begin
            // Drop the flow past the last column in use.
            f1_reg    <= (IDX < int'(ncols)) ? flow_in : '0;
            f2_reg    <= f1_reg;
            done3_reg <= f2_reg.vld && f2_reg.last;
            done4_reg <= done3_reg;
        end
    end

    // Operand stage, product stage, accumulate stage, add C.
    always_ff @(posedge clk)
    begin
        k1_reg   <= k_in;
        a1_reg   <= a_in;
        prod_reg <= a1_reg * b_rd_reg;
        acc_reg  <= acc_next;
        res_reg  <= acc_reg + (mma_pkg::ACC_W'(c_rd_reg) <<< 8);
    end

    assign flow_out = f1_reg;
    assign k_out    = k1_reg;
    assign a_out    = a1_reg;
    assign done     = done4_reg && (IDX < int'(ncols));
    assign last     = (IDX == int'(ncols) - 1);
    assign res      = res_reg;

endmodule

// ===== rtl/core/matrix_multiply_add.sv =====
// Top level: command decode, A store, row sequencer and the chain of column cells.
// A load does not raise busy; it gives no result.
// A compute holds busy while the k loop feeds the column chain and until the last
// column cell is done; results appear one per cycle.
// Results are strobed for one cycle each and cannot be stalled.
// Reset clears the control state and sets all dimensions to 16; stores are undefined.
module matrix_multiply_add #(
    parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mma_pkg::req_t             req,
    input  logic                      wr_en,
    input  logic [1:0]                wr_idx,
    input  logic [mma_pkg::DIM_W-1:0] wr_data,
    output logic                      strobe,
    output mma_pkg::res_t             result
);

    localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LIM = (MAX_DIM < mma_pkg::IDX_LIMIT) ? MAX_DIM : mma_pkg::IDX_LIMIT;
    localparam logic [mma_pkg::DIM_W-1:0] LIM_V = mma_pkg::DIM_W'(LIM);

    logic [mma_pkg::DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [mma_pkg::DIM_W-1:0] nrows, ninner, ncols;

    mma_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [3:0]      row_reg;
    logic            accept, ld_ok, go;
    logic            issue, issue_last;
    logic            row_done;
    mma_pkg::load_t  ld;

    logic [mma_pkg::ELEM_W-1:0]        a_mem [2**(2*AW)];
    logic signed [mma_pkg::ELEM_W-1:0] a_rd_reg;
    mma_pkg::flow_t                    feed_reg;
    logic [AW-1:0]                     feed_k_reg;

    mma_pkg::flow_t                    flow_c [MAX_DIM+1];
    logic [AW-1:0]                     k_c    [MAX_DIM+1];
    logic signed [mma_pkg::ELEM_W-1:0] a_c    [MAX_DIM+1];
    logic [MAX_DIM-1:0]                done_v;
    logic [MAX_DIM-1:0]                last_v;
    logic signed [mma_pkg::ACC_W-1:0]  res_v  [MAX_DIM];

    logic          strobe_reg;
    mma_pkg::res_t result_reg, result_next;

    assign nrows  = mma_pkg::eff_dim(rows_reg, LIM_V);
    assign ninner = mma_pkg::eff_dim(inner_reg, LIM_V);
    assign ncols  = mma_pkg::eff_dim(cols_reg, LIM_V);

    assign accept = start && !busy;
    assign ld_ok  = (int'(req.row) < LIM) && (int'(req.col) < LIM);
    assign go     = accept && (req.func == mma_pkg::FUNC_COMPUTE)
                    && ({1'b0, req.row} < nrows);

    always_comb
    begin
        ld.b_we = accept && ld_ok && (req.func == mma_pkg::FUNC_LOAD_B);
        ld.c_we = accept && ld_ok && (req.func == mma_pkg::FUNC_LOAD_C);
        ld.row  = req.row;
        ld.col  = req.col;
        ld.data = req.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= mma_pkg::DIM_W'(16);
            inner_reg <= mma_pkg::DIM_W'(16);
            cols_reg  <= mma_pkg::DIM_W'(16);
        end
        else if (wr_en)
        begin
            unique case (mma_pkg::reg_idx_t'(wr_idx))
                mma_pkg::REG_ROWS:  rows_reg  <= wr_data;
                mma_pkg::REG_INNER: inner_reg <= wr_data;
                mma_pkg::REG_COLS:  cols_reg  <= wr_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                k_next = '0;
                if (go)
                begin
                    state_next = mma_pkg::ST_FEED;
                end
            end
            mma_pkg::ST_FEED:
            begin
                k_next = k_reg + AW'(1);
                if (issue_last)
                begin
                    state_next = mma_pkg::ST_DRAIN;
                end
            end
            mma_pkg::ST_DRAIN:
            begin
                if (row_done)
                begin
                    state_next = mma_pkg::ST_IDLE;
                end
            end
            default: state_next = mma_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        busy       = (state_reg != mma_pkg::ST_IDLE);
        issue      = (state_reg == mma_pkg::ST_FEED);
        issue_last = issue && (int'(k_reg) == int'(ninner) - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mma_pkg::ST_IDLE;
            k_reg      <= '0;
            feed_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            feed_reg.vld   <= issue;
            feed_reg.first <= issue && (k_reg == '0);
            feed_reg.last  <= issue_last;
            strobe_reg     <= |done_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            row_reg <= req.row;
        end
        if (accept && ld_ok && (req.func == mma_pkg::FUNC_LOAD_A))
        begin
            a_mem[{AW'(req.row), AW'(req.col)}] <= req.value;
        end
        a_rd_reg   <= a_mem[{AW'(row_reg), k_reg}];
        feed_k_reg <= k_reg;
        result_reg <= result_next;
    end

    assign flow_c[0] = feed_reg;
    assign k_c[0]    = feed_k_reg;
    assign a_c[0]    = a_rd_reg;

    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        mma_cell #(
            .MAX_DIM (MAX_DIM),
            .IDX     (j),
            .AW      (AW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ld       (ld),
            .row      (AW'(row_reg)),
            .ncols    (ncols),
            .flow_in  (flow_c[j]),
            .k_in     (k_c[j]),
            .a_in     (a_c[j]),
            .flow_out (flow_c[j+1]),
            .k_out    (k_c[j+1]),
            .a_out    (a_c[j+1]),
            .done     (done_v[j]),
            .last     (last_v[j]),
            .res      (res_v[j])
        );
    end

    // Cells finish one per cycle, so at most one done is high.
    always_comb
    begin
        result_next = '0;
        row_done    = 1'b0;
        for (int j = 0; j < MAX_DIM; j++)
        begin
            if (done_v[j])
            begin
                result_next.result_row   = row_reg;
                result_next.result_col   = 4'(j);
                result_next.result_value = res_v[j];
                result_next.last_in_row  = last_v[j];
                row_done                 = last_v[j];
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_one_done: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(done_v))
        else $error("two column cells finished in the same cycle");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobed without a compute transaction in flight");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func != mma_pkg::FUNC_COMPUTE) |=> !busy)
        else $error("load transaction left the block busy");

endmodule
